### rtl/core/rse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rse_pkg;

   localparam int WORD_W          = 32;
   localparam int OPCODE_W        = 3;
   localparam int STATUS_W        = 2;
   localparam int DEPTH_OUT_W     = 7;
   localparam int STACK_DEPTH_DEF = 64;
   localparam int DIV_STEPS       = WORD_W;
   localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

   localparam logic [OPCODE_W-1:0] OP_PUSH = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_ADD  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_SUB  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_MUL  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_DIV  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DIVZERO   = 2'd3;

endpackage

`default_nettype wire

### rtl/core/rse_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface rse_req_if;
   logic                                  valid;
   logic                                  ready;
   logic        [rse_pkg::OPCODE_W-1:0]   opcode;
   logic signed [rse_pkg::WORD_W-1:0]     push_value;

   modport source (output valid, output opcode, output push_value, input ready);
   modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface rse_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic        [rse_pkg::STATUS_W-1:0]     status;
   logic signed [rse_pkg::WORD_W-1:0]       top_value;
   logic        [rse_pkg::DEPTH_OUT_W-1:0]  stack_depth;

   modport source (output valid, output status, output top_value, output stack_depth,
                   input ready);
   modport sink   (input valid, input status, input top_value, input stack_depth,
                   output ready);
endinterface

`default_nettype wire

### rtl/core/rse_stack_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module rse_stack_mem #(
   parameter int DEPTH  = rse_pkg::STACK_DEPTH_DEF,
   parameter int ADDR_W = $clog2(rse_pkg::STACK_DEPTH_DEF)
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [ADDR_W-1:0]          wr_addr,
   input  wire logic [rse_pkg::WORD_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [ADDR_W-1:0]          rd_addr,
   output      logic [rse_pkg::WORD_W-1:0] rd_data
);

   logic [rse_pkg::WORD_W-1:0] mem [DEPTH];
   logic [rse_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/rse_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module rse_divider (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [rse_pkg::WORD_W-1:0] dividend,
   input  wire logic [rse_pkg::WORD_W-1:0] divisor,
   output      logic                       done,
   output      logic [rse_pkg::WORD_W-1:0] quotient
);

   localparam int W = rse_pkg::WORD_W;

   localparam logic [1:0] D_IDLE = 2'd0;
   localparam logic [1:0] D_RUN  = 2'd1;
   localparam logic [1:0] D_FIX  = 2'd2;

   logic [1:0]                   state_ff, state_in;
   logic [rse_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [W:0]                   rem_ff, rem_in;
   logic [W-1:0]                 quo_ff, quo_in;
   logic [W-1:0]                 den_ff, den_in;
   logic                         neg_ff, neg_in;
   logic                         done_ff, done_in;
   logic [W-1:0]                 res_ff, res_in;
   logic [W:0]                   rem_shift;
   logic [W:0]                   diff;

   // restoring step, one quotient bit per cycle
   assign rem_shift = {rem_ff[W-1:0], quo_ff[W-1]};
   assign diff      = rem_shift - {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               quo_in   = dividend[W-1] ? (-dividend) : dividend;
               den_in   = divisor[W-1] ? (-divisor) : divisor;
               neg_in   = dividend[W-1] ^ divisor[W-1];
               rem_in   = '0;
               cnt_in   = rse_pkg::DIV_CNT_W'(rse_pkg::DIV_STEPS - 1);
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            if (!diff[W]) begin
               rem_in = diff;
               quo_in = {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_in = rem_shift;
               quo_in = {quo_ff[W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = D_FIX;
            end
         end
         D_FIX: begin
            res_in   = neg_ff ? (-quo_ff) : quo_ff;
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign done     = done_ff;
   assign quotient = res_ff;

endmodule

`default_nettype wire

### rtl/core/rpn_stack_evaluator_core.sv
`timescale 1ns / 1ps
`default_nettype none

// rpn stack evaluator
// req_if carries one operation per beat: opcode (push, add, sub, mul, div)
// and push_value, used by push only. rsp_if returns one beat per request
// with status, the new top of stack (zero when empty) and the depth.
// The top entry sits in a register, the entries below it in a synchronous
// memory with separate write and read ports; an arithmetic op reads the
// second entry, combines it with the top register and writes the result
// back as top. Push, rejected and unknown ops go from idle straight to the
// done state; add, sub and mul pass through the execute state, and divide
// also waits in the divider-wait state. One request is in work at a time;
// a new request is taken once the response is loaded and the core is back
// in idle. The radix-2 divider yields one quotient bit per cycle. The
// response sits in an output register: a new request is taken while it
// waits, and a finished result waits in the core while that register is
// full and rsp_if.ready is low.
// Reset empties the stack (depth zero) and drops any pending response; the
// memory itself is not cleared since entries above the depth are never read.

module rpn_stack_evaluator_core #(
   parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
   input wire logic    clock,
   input wire logic    reset,
   rse_req_if.sink     req_if,
   rse_rsp_if.source   rsp_if
);

   localparam int W      = rse_pkg::WORD_W;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int EXT_W  = CNT_W + rse_pkg::DEPTH_OUT_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DIVW = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]                     state_ff, state_in;
   logic [rse_pkg::OPCODE_W-1:0]   op_ff, op_in;
   logic [W-1:0]                   top_ff, top_in;
   logic [CNT_W-1:0]               depth_ff, depth_in;
   logic [rse_pkg::STATUS_W-1:0]   status_ff, status_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [rse_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [W-1:0]                   rsp_top_ff, rsp_top_in;
   logic [rse_pkg::DEPTH_OUT_W-1:0] rsp_depth_ff, rsp_depth_in;

   logic                           accept;
   logic                           rsp_load;
   logic [CNT_W-1:0]               depth_m1;
   logic [CNT_W-1:0]               depth_m2;
   logic [EXT_W-1:0]               depth_ext;
   logic                           wr_en;
   logic                           rd_en;
   logic [W-1:0]                   rd_data;
   logic                           div_start;
   logic                           div_done;
   logic [W-1:0]                   div_quo;

   assign accept   = req_if.valid && req_if.ready;
   assign depth_m1 = depth_ff - CNT_W'(1);
   assign depth_m2 = depth_ff - CNT_W'(2);
   assign depth_ext = EXT_W'(depth_ff);

   assign req_if.ready = (state_ff == S_IDLE);

   rse_stack_mem #(
      .DEPTH  (STACK_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (depth_m1[ADDR_W-1:0]),
      .wr_data (top_ff),
      .rd_en   (rd_en),
      .rd_addr (depth_m2[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   rse_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_data),
      .divisor  (top_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      top_in    = top_ff;
      depth_in  = depth_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_if.opcode;
               status_in = rse_pkg::ST_OK;
               state_in  = S_DONE;
               priority if (req_if.opcode == rse_pkg::OP_PUSH) begin
                  if (depth_ff >= CNT_W'(STACK_DEPTH)) begin
                     status_in = rse_pkg::ST_FULL;
                  end else begin
                     // old top moves down into the memory
                     wr_en    = (depth_ff != '0);
                     top_in   = req_if.push_value;
                     depth_in = depth_ff + CNT_W'(1);
                  end
               end else if (req_if.opcode == rse_pkg::OP_ADD ||
                            req_if.opcode == rse_pkg::OP_SUB ||
                            req_if.opcode == rse_pkg::OP_MUL ||
                            req_if.opcode == rse_pkg::OP_DIV) begin
                  if (depth_ff < CNT_W'(2)) begin
                     status_in = rse_pkg::ST_UNDERFLOW;
                  end else if (req_if.opcode == rse_pkg::OP_DIV && top_ff == '0) begin
                     status_in = rse_pkg::ST_DIVZERO;
                  end else begin
                     rd_en    = 1'b1;
                     state_in = S_EXEC;
                  end
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_EXEC: begin
            // rd_data is the second entry, top_ff the first popped
            state_in = S_DONE;
            depth_in = depth_m1;
            unique case (op_ff)
               rse_pkg::OP_ADD: top_in = rd_data + top_ff;
               rse_pkg::OP_SUB: top_in = rd_data - top_ff;
               rse_pkg::OP_MUL: top_in = rd_data * top_ff;
               rse_pkg::OP_DIV: begin
                  div_start = 1'b1;
                  depth_in  = depth_ff;
                  state_in  = S_DIVW;
               end
               default: depth_in = depth_ff;
            endcase
         end
         S_DIVW: begin
            if (div_done) begin
               top_in   = div_quo;
               depth_in = depth_m1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_depth_in  = rsp_depth_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_top_in    = (depth_ff != '0) ? top_ff : '0;
         rsp_depth_in  = depth_ext[rse_pkg::DEPTH_OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      top_ff        <= top_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.top_value   = rsp_top_ff;
   assign rsp_if.stack_depth = rsp_depth_ff;

   a_depth_bound : assert property (@(posedge clock) disable iff (reset)
      depth_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack depth above capacity");

   a_write_in_range : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (depth_ff != '0 && depth_ff < CNT_W'(STACK_DEPTH)))
      else $error("stack memory write outside held entries");

   a_read_two_held : assert property (@(posedge clock) disable iff (reset)
      rd_en |=> (state_ff == S_EXEC && depth_ff >= CNT_W'(2)))
      else $error("operand read without two entries");

   a_div_nonzero : assert property (@(posedge clock) disable iff (reset)
      div_start |-> (top_ff != '0 && op_ff == rse_pkg::OP_DIV))
      else $error("divider started with zero divisor");

   a_rsp_from_done : assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("response load did not present a beat");

endmodule

`default_nettype wire
